// File: hw/rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// shared constants and types for the box overlap test
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned NumSlots      = 10;
  localparam int unsigned SlotWidth     = 4;
  localparam int unsigned EpsWidth      = 16;
  localparam int unsigned EpsResetVal   = 66;
  localparam int unsigned CompWidth     = 32;

  localparam logic [SlotWidth-1:0] SlotAc  = 4'd0;
  localparam logic [SlotWidth-1:0] SlotAx0 = 4'd1;
  localparam logic [SlotWidth-1:0] SlotAe  = 4'd4;
  localparam logic [SlotWidth-1:0] SlotBc  = 4'd5;
  localparam logic [SlotWidth-1:0] SlotBx0 = 4'd6;
  localparam logic [SlotWidth-1:0] SlotBe  = 4'd9;

  typedef enum logic [1:0] {
    ExIdle,
    ExLoad,
    ExRun,
    ExDone
  } ex_state_e;

  typedef struct packed {
    logic [SlotWidth-1:0] slot;
    logic [CompWidth-1:0] x;
    logic [CompWidth-1:0] y;
    logic [CompWidth-1:0] z;
    logic                 last;
  } item_t;

endpackage

// File: hw/rtl/obb_front.sv
// ----------------------------------------------------------------------------
// obb_front
// accepts load transactions and queues them for the execution unit
// ----------------------------------------------------------------------------
module obb_front import obb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  item_t item_i,
  output logic  busy_o,
  input  logic  pop_i,
  output logic  avail_o,
  output item_t item_o
);
  localparam int unsigned Depth = 4;

  item_t       fifo_q [Depth];
  logic [1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        push;

  assign busy_o  = (cnt_q == 3'(Depth));
  assign push    = start_i && !busy_o;
  assign avail_o = (cnt_q != 3'd0);
  assign item_o  = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 2'd1 : wr_q;
    rd_d  = (pop_i && avail_o) ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + 3'(push) - 3'(pop_i && avail_o);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// File: hw/rtl/obb_exec.sv
// ----------------------------------------------------------------------------
// obb_exec
// stores box vectors and runs the separating axis test on two shared
// multipliers, one product each per cycle
// ----------------------------------------------------------------------------
module obb_exec import obb_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDef,
  parameter int unsigned FracBits   = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [EpsWidth-1:0] eps_i,
  input  logic                avail_i,
  input  item_t               item_i,
  output logic                pop_o,
  output logic                valid_o,
  output logic                overlap_o
);
  localparam int unsigned W = CoordWidth;
  localparam logic signed [W-1:0] VMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMin = {1'b1, {(W-1){1'b0}}};
  localparam int unsigned StoreDepth = NumSlots * 3;

  typedef logic signed [W-1:0] val_t;

  logic [CompWidth-1:0] vec_q [StoreDepth];
  logic [NumSlots-1:0]  vld_q;

  ex_state_e  st_q, st_d;
  logic [4:0] axis_q;
  logic [1:0] sub_q;
  logic [1:0] nsub;
  logic       axis_done;
  logic       slot_ok;
  logic       sep_q;
  logic       valid_q;
  val_t       r_q [9];
  val_t       ar_q [9];
  val_t       t_q [3];
  val_t       d_q [3];
  val_t       acc_q, acc2_q, p_q;
  val_t       ma, mb, pa, pb, term, pp, eps_v;
  logic [3:0] rel9;
  logic [1:0] rel3, gi, gj, gi1, gi2, gj1, gj2;

  function automatic val_t sat_f(input logic signed [W+1:0] x);
    if (x > (W+2)'(VMax)) return VMax;
    if (x < (W+2)'(VMin)) return VMin;
    return x[W-1:0];
  endfunction

  function automatic val_t sadd(input val_t a, input val_t b);
    return sat_f((W+2)'(a) + (W+2)'(b));
  endfunction

  function automatic val_t ssub(input val_t a, input val_t b);
    return sat_f((W+2)'(a) - (W+2)'(b));
  endfunction

  function automatic val_t sabs(input val_t a);
    return sat_f(a[W-1] ? -(W+2)'(a) : (W+2)'(a));
  endfunction

  // saturating product, truncation toward zero
  function automatic val_t smul(input val_t a, input val_t b);
    logic           neg;
    logic [W-1:0]   ua, ub;
    logic [2*W-1:0] pr, sh, lim;
    neg = a[W-1] ^ b[W-1];
    ua  = a[W-1] ? W'(-a) : W'(a);
    ub  = b[W-1] ? W'(-b) : W'(b);
    pr  = (2*W)'(ua) * (2*W)'(ub);
    sh  = pr >> FracBits;
    lim = neg ? (2*W)'(VMax) + (2*W)'(1) : (2*W)'(VMax);
    if (sh > lim) sh = lim;
    return neg ? W'(-sh) : W'(sh);
  endfunction

  function automatic val_t comp(input logic [CompWidth-1:0] v);
    logic signed [CompWidth:0] e;
    e = $signed({v[CompWidth-1], v});
    if (e > (CompWidth+1)'(VMax) && W < CompWidth) return VMax;
    if (e < $signed((CompWidth+1)'(VMin)) && W < CompWidth) return VMin;
    return W'(e);
  endfunction

  function automatic logic [4:0] vix(input logic [SlotWidth-1:0] s, input logic [1:0] c);
    return 5'(s) * 5'd3 + 5'(c);
  endfunction

  function automatic val_t getc(input logic [SlotWidth-1:0] s, input logic [1:0] c);
    return vld_q[s] ? comp(vec_q[vix(s, c)]) : '0;
  endfunction

  function automatic logic [3:0] ix9(input logic [1:0] i, input logic [1:0] j);
    return 4'(i) * 4'd3 + 4'(j);
  endfunction

  function automatic logic [1:0] nx3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  function automatic logic [3:0] split9(input logic [3:0] n);
    case (n)
      4'd0:    return {2'd0, 2'd0};
      4'd1:    return {2'd0, 2'd1};
      4'd2:    return {2'd0, 2'd2};
      4'd3:    return {2'd1, 2'd0};
      4'd4:    return {2'd1, 2'd1};
      4'd5:    return {2'd1, 2'd2};
      4'd6:    return {2'd2, 2'd0};
      4'd7:    return {2'd2, 2'd1};
      4'd8:    return {2'd2, 2'd2};
      default: return '0;
    endcase
  endfunction

  // axis groups: 0..8 rotation entries, 9..11 offset, 12..14 offset in A frame,
  // 15..17 A axes, 18..20 B axes, 21..29 cross axes
  always_comb begin
    rel9 = (axis_q >= 5'd21) ? 4'(axis_q - 5'd21) : axis_q[3:0];
    if (axis_q < 5'd12) begin
      rel3 = 2'(axis_q - 5'd9);
    end else if (axis_q < 5'd15) begin
      rel3 = 2'(axis_q - 5'd12);
    end else if (axis_q < 5'd18) begin
      rel3 = 2'(axis_q - 5'd15);
    end else begin
      rel3 = 2'(axis_q - 5'd18);
    end
    {gi, gj} = split9(rel9);
    gi1 = nx3(gi);
    gi2 = nx3(gi1);
    gj1 = nx3(gj);
    gj2 = nx3(gj1);
  end

  always_comb begin
    ma = '0; mb = '0; pa = '0; pb = '0; nsub = 2'd2;
    if (axis_q < 5'd9) begin
      ma = getc(SlotAx0 + 4'(gi), sub_q);
      mb = getc(SlotBx0 + 4'(gj), sub_q);
    end else if (axis_q < 5'd12) begin
      nsub = 2'd0;
    end else if (axis_q < 5'd15) begin
      ma = d_q[sub_q];
      mb = getc(SlotAx0 + 4'(rel3), sub_q);
    end else if (axis_q < 5'd18) begin
      ma = getc(SlotBe, sub_q);
      mb = ar_q[ix9(rel3, sub_q)];
    end else if (axis_q < 5'd21) begin
      nsub = 2'd3;
      if (sub_q != 2'd3) begin
        ma = getc(SlotAe, sub_q);
        mb = ar_q[ix9(sub_q, rel3)];
        pa = t_q[sub_q];
        pb = r_q[ix9(sub_q, rel3)];
      end
    end else begin
      nsub = 2'd3;
      case (sub_q)
        2'd0: begin
          ma = getc(SlotAe, gi1); mb = ar_q[ix9(gi2, gj)];
          pa = t_q[gi2];          pb = r_q[ix9(gi1, gj)];
        end
        2'd1: begin
          ma = getc(SlotAe, gi2); mb = ar_q[ix9(gi1, gj)];
          pa = t_q[gi1];          pb = r_q[ix9(gi2, gj)];
        end
        2'd2: begin
          ma = getc(SlotBe, gj1); mb = ar_q[ix9(gi, gj2)];
        end
        default: begin
          ma = getc(SlotBe, gj2); mb = ar_q[ix9(gi, gj1)];
        end
      endcase
    end
  end

  assign term      = smul(ma, mb);
  assign pp        = smul(pa, pb);
  assign eps_v     = sat_f((W+2)'(eps_i));
  assign axis_done = (sub_q == nsub);
  assign slot_ok   = (item_i.slot < SlotWidth'(NumSlots));

  always_comb begin
    st_d = st_q;
    case (st_q)
      ExIdle: if (avail_i) st_d = ExLoad;
      ExLoad: st_d = item_i.last ? ExRun : ExIdle;
      ExRun:  if (axis_done && (axis_q == 5'd29 || sep_q)) st_d = ExDone;
      ExDone: st_d = ExIdle;
      default: st_d = ExIdle;
    endcase
  end

  always_comb begin
    pop_o     = (st_q == ExLoad);
    valid_o   = valid_q;
    overlap_o = !sep_q;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ExLoad && slot_ok) begin
      vec_q[vix(item_i.slot, 2'd0)] <= item_i.x;
      vec_q[vix(item_i.slot, 2'd1)] <= item_i.y;
      vec_q[vix(item_i.slot, 2'd2)] <= item_i.z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ExRun) begin
      if (!axis_done) begin
        if (axis_q >= 5'd21) begin
          case (sub_q)
            2'd0: begin
              acc_q <= term;
              p_q   <= pp;
            end
            2'd1: begin
              acc2_q <= sadd(acc_q, term);
              p_q    <= ssub(p_q, pp);
            end
            default: acc_q <= term;
          endcase
        end else begin
          acc_q <= (sub_q == 2'd0) ? term : sadd(acc_q, term);
          p_q   <= (sub_q == 2'd0) ? pp : sadd(p_q, pp);
        end
      end else if (axis_q < 5'd9) begin
        r_q[rel9]  <= sadd(acc_q, term);
        ar_q[rel9] <= sadd(sabs(sadd(acc_q, term)), eps_v);
      end else if (axis_q < 5'd12) begin
        d_q[rel3] <= ssub(getc(SlotBc, rel3), getc(SlotAc, rel3));
      end else if (axis_q < 5'd15) begin
        t_q[rel3] <= sadd(acc_q, term);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ExIdle;
      vld_q   <= '0;
      axis_q  <= '0;
      sub_q   <= '0;
      sep_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_q <= (st_q == ExRun) && (st_d == ExDone);
      if (st_q == ExLoad) begin
        if (slot_ok) vld_q[item_i.slot] <= 1'b1;
        axis_q <= '0;
        sub_q  <= '0;
        sep_q  <= 1'b0;
      end else if (st_q == ExRun) begin
        if (!axis_done) begin
          sub_q <= sub_q + 2'd1;
        end else begin
          sub_q  <= '0;
          axis_q <= axis_q + 5'd1;
          if (axis_q >= 5'd15 && axis_q < 5'd18) begin
            if (sabs(t_q[rel3]) > sadd(getc(SlotAe, rel3), sadd(acc_q, term))) sep_q <= 1'b1;
          end else if (axis_q >= 5'd18 && axis_q < 5'd21) begin
            if (sabs(p_q) > sadd(acc_q, getc(SlotBe, rel3))) sep_q <= 1'b1;
          end else if (axis_q >= 5'd21) begin
            if (sabs(p_q) > sadd(acc2_q, sadd(acc_q, term))) sep_q <= 1'b1;
          end
        end
      end
    end
  end
endmodule

// File: hw/rtl/obb_obb_separating_axis_test.sv
// ----------------------------------------------------------------------------
// obb_obb_separating_axis_test
// oriented box overlap by the 15-axis separating axis test
// ----------------------------------------------------------------------------
// flow: an accepted load is written to the queue, then stored while the back end
// is in its load state; done_o is raised when the run ends at the last cross axis,
// or earlier when an axis separates before the last cross axis
// the back end passes through an idle and a load state for each load, and holds
// a last load for its whole run on two shared multipliers; a 4-entry queue keeps accepting
// reset: marks all store slots empty so they read as zero, epsilon to 66; results cannot be stalled
module obb_obb_separating_axis_test import obb_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDef,
  parameter int unsigned FracBits   = FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [EpsWidth-1:0]  cfg_wdata_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [SlotWidth-1:0] slot_i,
  input  logic [CompWidth-1:0] comp_x_i,
  input  logic [CompWidth-1:0] comp_y_i,
  input  logic [CompWidth-1:0] comp_z_i,
  input  logic                 last_i,
  output logic                 done_o,
  output logic                 overlap_o
);
  logic [EpsWidth-1:0] eps_q;
  item_t in_item, q_item;
  logic  q_avail, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsWidth'(EpsResetVal);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  assign in_item = '{slot: slot_i, x: comp_x_i, y: comp_y_i, z: comp_z_i, last: last_i};

  obb_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i(in_item), .busy_o,
    .pop_i(q_pop), .avail_o(q_avail), .item_o(q_item)
  );

  obb_exec #(.CoordWidth(CoordWidth), .FracBits(FracBits)) u_exec (
    .clk_i, .rst_ni, .eps_i(eps_q), .avail_i(q_avail), .item_i(q_item),
    .pop_o(q_pop), .valid_o(done_o), .overlap_o
  );
endmodule
